@@ rtl/hbbc_pkg.sv @@
// ----------------------------------------------------------------------------
// hbbc_pkg
// shared constants, codes, control types and the bucket modulo step
// ----------------------------------------------------------------------------
package hbbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int NUM_BUCKETS = 13;

  localparam int BUF_W   = $clog2(NUM_BUFFERS);
  localparam int CUR_W   = $clog2(NUM_BUFFERS + 1);
  localparam int BKT_W   = $clog2(NUM_BUCKETS + 1);
  localparam int FREE_W  = 6;
  localparam int COUNT_W = 8;
  localparam int BLK_W   = 32;
  localparam int DEV_W   = 8;
  localparam int MOD_STEPS = BLK_W / 2;
  localparam int MCNT_W  = $clog2(MOD_STEPS);

  localparam logic [CUR_W-1:0]   NIL_LINK  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [FREE_W-1:0]  FREE_MAX  = '1;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_ZERO    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MODLOAD,
    OP_MODSTEP,
    OP_WALK_INIT,
    OP_WALK_STEP,
    OP_HIT,
    OP_TAKE,
    OP_SB_FIRST,
    OP_SB_NEXT,
    OP_UNLINK,
    OP_LINK,
    OP_FAIL,
    OP_CMD,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   use_sb;
  } dp_ctl_t;

  typedef struct packed {
    logic is_get;
    logic mod_done;
    logic walk_live;
    logic tag_match;
    logic ref_zero;
    logic free_nz;
    logic sb_is_tb;
    logic sb_last;
  } dp_stat_t;

  // one radix-4 digit of block_number modulo NUM_BUCKETS
  function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] r,
                                                input logic [1:0] d);
    logic [BKT_W+1:0] v;
    v = {r, d};
    if (v >= (BKT_W+2)'(3 * NUM_BUCKETS)) begin
      v = v - (BKT_W+2)'(3 * NUM_BUCKETS);
    end else if (v >= (BKT_W+2)'(2 * NUM_BUCKETS)) begin
      v = v - (BKT_W+2)'(2 * NUM_BUCKETS);
    end else if (v >= (BKT_W+2)'(NUM_BUCKETS)) begin
      v = v - (BKT_W+2)'(NUM_BUCKETS);
    end
    return v[BKT_W-1:0];
  endfunction

endpackage

@@ rtl/hbbc_if.sv @@
// ----------------------------------------------------------------------------
// hbbc_if
// request and response channels of the buffer cache
// ----------------------------------------------------------------------------
interface hbbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [4:0]  buffer_index;

  modport source (output valid, command, device, block_number, buffer_index,
                  input ready);
  modport sink (input valid, command, device, block_number, buffer_index,
                output ready);
endinterface

interface hbbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] granted_buffer;
  logic       tag_hit;
  logic       needs_disk_read;
  logic [7:0] reference_count;

  modport source (output valid, status, granted_buffer, tag_hit, needs_disk_read,
                  reference_count, input ready);
  modport sink (input valid, status, granted_buffer, tag_hit, needs_disk_read,
                reference_count, output ready);
endinterface

@@ rtl/hbbc_datapath.sv @@
// ----------------------------------------------------------------------------
// hbbc_datapath
// buffer tags, counts, bucket lists, modulo unit and result registers
// ----------------------------------------------------------------------------
module hbbc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  hbbc_pkg::dp_ctl_t ctl,
  output hbbc_pkg::dp_stat_t stat,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_device,
  input  logic [31:0]       in_block_number,
  input  logic [4:0]        in_buffer_index,
  output logic [1:0]        status,
  output logic [4:0]        granted_buffer,
  output logic              tag_hit,
  output logic              needs_disk_read,
  output logic [7:0]        reference_count
);
  import hbbc_pkg::*;

  logic [DEV_W-1:0]   tag_dev  [NUM_BUFFERS];
  logic [BLK_W-1:0]   tag_blk  [NUM_BUFFERS];
  logic [COUNT_W-1:0] refc     [NUM_BUFFERS];
  logic               cvalid   [NUM_BUFFERS];
  logic [CUR_W-1:0]   nlink    [NUM_BUFFERS];
  logic [CUR_W-1:0]   head     [NUM_BUCKETS];
  logic [FREE_W-1:0]  freec    [NUM_BUCKETS];

  command_t         cmd_r;
  logic [DEV_W-1:0] dev_r;
  logic [BLK_W-1:0] blk_r;
  logic [BLK_W-1:0] word;
  logic [BKT_W-1:0] tb;
  logic [BKT_W-1:0] sb;
  logic [MCNT_W-1:0] mcnt;
  logic [CUR_W-1:0] cur;
  logic [CUR_W-1:0] prev;
  logic [CUR_W-1:0] steps;

  logic [1:0]         res_status;
  logic [CUR_W-1:0]   res_buf;
  logic               res_hit;
  logic               res_ndr;
  logic [COUNT_W-1:0] res_rc;

  logic [BKT_W-1:0]   bsel;
  logic [BUF_W-1:0]   ci;
  logic [BUF_W-1:0]   pi;
  logic [CUR_W-1:0]   head_b;
  logic [FREE_W-1:0]  free_b;
  logic [CUR_W-1:0]   nxt;
  logic [COUNT_W-1:0] rc_c;
  logic               idx_ok;

  assign bsel   = ctl.use_sb ? sb : tb;
  assign ci     = cur[BUF_W-1:0];
  assign pi     = prev[BUF_W-1:0];
  assign head_b = head[bsel];
  assign free_b = freec[bsel];
  assign nxt    = nlink[ci];
  assign rc_c   = refc[ci];
  assign idx_ok = cur < CUR_W'(NUM_BUFFERS);

  assign stat.is_get    = (cmd_r == CMD_GET);
  assign stat.mod_done  = (mcnt == MCNT_W'(MOD_STEPS - 1));
  assign stat.walk_live = idx_ok && (steps < CUR_W'(NUM_BUFFERS));
  assign stat.tag_match = (tag_dev[ci] == dev_r) && (tag_blk[ci] == blk_r);
  assign stat.ref_zero  = (rc_c == '0);
  assign stat.free_nz   = (free_b != '0);
  assign stat.sb_is_tb  = (sb == tb);
  assign stat.sb_last   = (sb == BKT_W'(NUM_BUCKETS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_dev[i] <= '0;
        tag_blk[i] <= '0;
        refc[i]    <= '0;
        cvalid[i]  <= 1'b0;
        nlink[i]   <= (i + 1 < NUM_BUFFERS) ? CUR_W'(i + 1) : NIL_LINK;
      end
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        head[b]  <= (b == 0) ? '0 : NIL_LINK;
        freec[b] <= (b == 0) ? FREE_W'(NUM_BUFFERS) : '0;
      end
      cmd_r <= CMD_GET;
      dev_r <= '0;
      blk_r <= '0;
      word  <= '0;
      tb    <= '0;
      sb    <= '0;
      mcnt  <= '0;
      cur   <= '0;
      prev  <= NIL_LINK;
      steps <= '0;
      res_status <= ST_OK;
      res_buf    <= '0;
      res_hit    <= 1'b0;
      res_ndr    <= 1'b0;
      res_rc     <= '0;
      status          <= ST_OK;
      granted_buffer  <= '0;
      tag_hit         <= 1'b0;
      needs_disk_read <= 1'b0;
      reference_count <= '0;
    end else begin
      case (ctl.op)
        OP_ACCEPT: begin
          cmd_r <= command_t'(in_command);
          dev_r <= in_device;
          blk_r <= in_block_number;
          cur   <= CUR_W'(in_buffer_index);
        end
        OP_MODLOAD: begin
          word <= (cmd_r == CMD_GET) ? blk_r : (idx_ok ? tag_blk[ci] : '0);
          tb   <= '0;
          mcnt <= '0;
        end
        OP_MODSTEP: begin
          tb   <= mod_step(tb, word[BLK_W-1:BLK_W-2]);
          word <= {word[BLK_W-3:0], 2'b00};
          mcnt <= mcnt + 1'b1;
        end
        OP_WALK_INIT: begin
          cur   <= head_b;
          prev  <= NIL_LINK;
          steps <= '0;
        end
        OP_WALK_STEP: begin
          prev  <= cur;
          cur   <= nxt;
          steps <= steps + 1'b1;
        end
        OP_HIT: begin
          if (rc_c == '0 && free_b != '0) freec[bsel] <= free_b - 1'b1;
          if (rc_c != COUNT_MAX) refc[ci] <= rc_c + 1'b1;
          cvalid[ci] <= 1'b1;
          res_status <= ST_OK;
          res_buf    <= cur;
          res_hit    <= 1'b1;
          res_ndr    <= !cvalid[ci];
          res_rc     <= (rc_c != COUNT_MAX) ? rc_c + 1'b1 : rc_c;
        end
        OP_TAKE, OP_LINK: begin
          if (ctl.op == OP_TAKE) begin
            freec[bsel] <= free_b - 1'b1;
          end else begin
            nlink[ci]  <= head_b;
            head[bsel] <= cur;
          end
          tag_dev[ci] <= dev_r;
          tag_blk[ci] <= blk_r;
          refc[ci]    <= COUNT_W'(1);
          cvalid[ci]  <= 1'b1;
          res_status  <= ST_OK;
          res_buf     <= cur;
          res_hit     <= 1'b0;
          res_ndr     <= 1'b1;
          res_rc      <= COUNT_W'(1);
        end
        OP_SB_FIRST: sb <= '0;
        OP_SB_NEXT:  sb <= sb + 1'b1;
        OP_UNLINK: begin
          if (prev == NIL_LINK) head[bsel] <= nxt;
          else nlink[pi] <= nxt;
          freec[bsel] <= free_b - 1'b1;
        end
        OP_FAIL: begin
          res_status <= ST_NO_FREE;
          res_buf    <= '0;
          res_hit    <= 1'b0;
          res_ndr    <= 1'b0;
          res_rc     <= '0;
        end
        OP_CMD: begin
          res_status <= ST_OK;
          res_buf    <= cur;
          res_hit    <= 1'b0;
          res_ndr    <= 1'b0;
          res_rc     <= '0;
          if (idx_ok) begin
            if (cmd_r == CMD_PIN) begin
              if (rc_c == '0 && free_b != '0) freec[bsel] <= free_b - 1'b1;
              if (rc_c != COUNT_MAX) refc[ci] <= rc_c + 1'b1;
              res_rc <= (rc_c != COUNT_MAX) ? rc_c + 1'b1 : rc_c;
            end else if (rc_c == '0) begin
              res_status <= ST_ZERO;
            end else begin
              refc[ci] <= rc_c - 1'b1;
              res_rc   <= rc_c - 1'b1;
              if (rc_c == COUNT_W'(1) && free_b != FREE_MAX) begin
                freec[bsel] <= free_b + 1'b1;
              end
            end
          end
        end
        OP_EMIT: begin
          status          <= res_status;
          granted_buffer  <= 5'(res_buf);
          tag_hit         <= res_hit;
          needs_disk_read <= res_ndr;
          reference_count <= res_rc;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/hbbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbbc_ctrl
// sequencer for get, release, pin and unpin
// ----------------------------------------------------------------------------
module hbbc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output hbbc_pkg::dp_ctl_t  ctl,
  input  hbbc_pkg::dp_stat_t stat
);
  import hbbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MODLOAD, S_MODRUN, S_SINIT, S_SEARCH, S_HIT, S_RINIT, S_REUSE,
    S_STEAL_SEL, S_STEAL_WALK, S_LINK, S_FAIL, S_CMD, S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit;

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    ctl.use_sb = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_ACCEPT;
          state_next = S_MODLOAD;
        end
      end
      S_MODLOAD: begin
        ctl.op     = OP_MODLOAD;
        state_next = S_MODRUN;
      end
      S_MODRUN: begin
        ctl.op = OP_MODSTEP;
        if (stat.mod_done) state_next = stat.is_get ? S_SINIT : S_CMD;
      end
      S_SINIT: begin
        ctl.op     = OP_WALK_INIT;
        state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.walk_live && stat.tag_match) begin
          state_next = S_HIT;
        end else if (stat.walk_live) begin
          ctl.op = OP_WALK_STEP;
        end else begin
          state_next = S_RINIT;
        end
      end
      S_HIT: begin
        ctl.op     = OP_HIT;
        state_next = S_EMIT;
      end
      S_RINIT: begin
        ctl.op     = OP_WALK_INIT;
        state_next = S_REUSE;
      end
      S_REUSE: begin
        if (stat.walk_live && stat.free_nz && stat.ref_zero) begin
          ctl.op     = OP_TAKE;
          state_next = S_EMIT;
        end else if (stat.walk_live && stat.free_nz) begin
          ctl.op = OP_WALK_STEP;
        end else begin
          ctl.op     = OP_SB_FIRST;
          state_next = S_STEAL_SEL;
        end
      end
      S_STEAL_SEL: begin
        ctl.use_sb = 1'b1;
        if (stat.sb_is_tb) begin
          if (stat.sb_last) state_next = S_FAIL;
          else ctl.op = OP_SB_NEXT;
        end else begin
          ctl.op     = OP_WALK_INIT;
          state_next = S_STEAL_WALK;
        end
      end
      S_STEAL_WALK: begin
        ctl.use_sb = 1'b1;
        if (stat.walk_live && stat.free_nz && stat.ref_zero) begin
          ctl.op     = OP_UNLINK;
          state_next = S_LINK;
        end else if (stat.walk_live && stat.free_nz) begin
          ctl.op = OP_WALK_STEP;
        end else if (stat.sb_last) begin
          state_next = S_FAIL;
        end else begin
          ctl.op     = OP_SB_NEXT;
          state_next = S_STEAL_SEL;
        end
      end
      S_LINK: begin
        ctl.op     = OP_LINK;
        state_next = S_EMIT;
      end
      S_FAIL: begin
        ctl.op     = OP_FAIL;
        state_next = S_EMIT;
      end
      S_CMD: begin
        ctl.op     = OP_CMD;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit) begin
          ctl.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= emit || (out_valid && !out_ready);
    end
  end

endmodule

@@ rtl/hashed_block_buffer_cache_unit.sv @@
// release, pin and unpin pass through the modulo unit and one command step;
// get passes through the modulo unit and then walks the bucket lists
// the time taken is set by the 2-bit-per-cycle modulo unit and the list walk,
// which follows one buffer link per cycle; one item is in work at a time
// reset: every buffer in bucket 0 in index order, counts and tags zero
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_unit
// hashed bucket buffer cache with reference counts, top level
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache_unit (
  input logic       clk,
  input logic       rst,
  hbbc_req_if.sink  req,
  hbbc_rsp_if.source rsp
);
  import hbbc_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  hbbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  hbbc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .in_command      (req.command),
    .in_device       (req.device),
    .in_block_number (req.block_number),
    .in_buffer_index (req.buffer_index),
    .status          (rsp.status),
    .granted_buffer  (rsp.granted_buffer),
    .tag_hit         (rsp.tag_hit),
    .needs_disk_read (rsp.needs_disk_read),
    .reference_count (rsp.reference_count)
  );

endmodule

@@ dv/tb_hashed_block_buffer_cache_unit.sv @@
// ----------------------------------------------------------------------------
// tb_hashed_block_buffer_cache_unit
// drives get, release, pin and unpin items through the request channel with
// bursty gaps, and predicts every response from a model of the hashed bucket
// lists, tags and reference counts; responses taken with or without stalls
// ----------------------------------------------------------------------------
module tb_hashed_block_buffer_cache_unit;
  import hbbc_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [4:0] granted_buffer;
    logic       tag_hit;
    logic       needs_disk_read;
    logic [7:0] reference_count;
  } cache_rsp_t;

  logic clk;
  logic rst;
  hbbc_req_if req ();
  hbbc_rsp_if rsp ();

  hashed_block_buffer_cache_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // model state
  logic [7:0]  mdl_device [NUM_BUFFERS];
  logic [31:0] mdl_block  [NUM_BUFFERS];
  int          mdl_refs   [NUM_BUFFERS];
  bit          mdl_valid  [NUM_BUFFERS];
  int          mdl_next   [NUM_BUFFERS];
  int          mdl_head   [NUM_BUCKETS];
  int          mdl_free   [NUM_BUCKETS];

  cache_rsp_t expected_rsps[$];
  int         error_count;
  int         sent_count;
  int         rsp_count;
  int         hit_count;
  int         steal_count;
  int         nofree_count;
  int         zero_count;
  bit         stall_enable;

  localparam int NIL = -1;

  function automatic void cache_reset();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      mdl_device[i] = '0;
      mdl_block[i]  = '0;
      mdl_refs[i]   = 0;
      mdl_valid[i]  = 1'b0;
      mdl_next[i]   = (i + 1 < NUM_BUFFERS) ? i + 1 : NIL;
    end
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      mdl_head[b] = NIL;
      mdl_free[b] = 0;
    end
    mdl_head[0] = 0;
    mdl_free[0] = NUM_BUFFERS;
  endfunction

  function automatic cache_rsp_t cache_get(logic [7:0] dev, logic [31:0] blk);
    cache_rsp_t r;
    int tb;
    int cur;
    int prev;
    int chosen;
    bit hit;
    r = '0;
    tb = int'(blk % NUM_BUCKETS);
    chosen = NIL;
    hit = 1'b0;
    cur = mdl_head[tb];
    for (int s = 0; cur != NIL && s < NUM_BUFFERS; s++) begin
      if (mdl_device[cur] == dev && mdl_block[cur] == blk) begin
        chosen = cur;
        hit = 1'b1;
        break;
      end
      cur = mdl_next[cur];
    end
    if (hit) begin
      hit_count++;
      if (mdl_refs[chosen] == 0 && mdl_free[tb] > 0) mdl_free[tb]--;
      if (mdl_refs[chosen] < 255) mdl_refs[chosen]++;
    end else begin
      cur = mdl_head[tb];
      for (int s = 0; cur != NIL && s < NUM_BUFFERS && mdl_free[tb] > 0; s++) begin
        if (mdl_refs[cur] == 0) begin
          chosen = cur;
          mdl_free[tb]--;
          break;
        end
        cur = mdl_next[cur];
      end
      for (int sb = 0; chosen == NIL && sb < NUM_BUCKETS; sb++) begin
        if (sb == tb) continue;
        prev = NIL;
        cur = mdl_head[sb];
        for (int s = 0; cur != NIL && s < NUM_BUFFERS && mdl_free[sb] > 0; s++) begin
          if (mdl_refs[cur] == 0) begin
            if (prev == NIL) mdl_head[sb] = mdl_next[cur];
            else mdl_next[prev] = mdl_next[cur];
            mdl_free[sb]--;
            mdl_next[cur] = mdl_head[tb];
            mdl_head[tb] = cur;
            chosen = cur;
            steal_count++;
            break;
          end
          prev = cur;
          cur = mdl_next[cur];
        end
      end
      if (chosen == NIL) begin
        nofree_count++;
        r.status = ST_NO_FREE;
        return r;
      end
      mdl_device[chosen] = dev;
      mdl_block[chosen]  = blk;
      mdl_valid[chosen]  = 1'b0;
      mdl_refs[chosen]   = 1;
    end
    r.status          = ST_OK;
    r.granted_buffer  = chosen[4:0];
    r.tag_hit         = hit;
    r.needs_disk_read = !mdl_valid[chosen];
    r.reference_count = mdl_refs[chosen][7:0];
    mdl_valid[chosen] = 1'b1;
    return r;
  endfunction

  function automatic cache_rsp_t cache_predict(command_t cmd, logic [7:0] dev,
                                               logic [31:0] blk, logic [4:0] idx);
    cache_rsp_t r;
    int bk;
    if (cmd == CMD_GET) return cache_get(dev, blk);
    r = '0;
    r.status = ST_OK;
    r.granted_buffer = idx;
    if (int'(idx) >= NUM_BUFFERS) return r;
    bk = int'(mdl_block[idx] % NUM_BUCKETS);
    if (cmd == CMD_PIN) begin
      if (mdl_refs[idx] == 0 && mdl_free[bk] > 0) mdl_free[bk]--;
      if (mdl_refs[idx] < 255) mdl_refs[idx]++;
    end else if (mdl_refs[idx] == 0) begin
      r.status = ST_ZERO;
      zero_count++;
    end else begin
      mdl_refs[idx]--;
      if (mdl_refs[idx] == 0 && mdl_free[bk] < 63) mdl_free[bk]++;
    end
    r.reference_count = mdl_refs[idx][7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("mismatch on response %0d: %s got %0d expected %0d", rsp_count, what,
             got, want);
  endtask

  // sender: random gaps, bursts come from sequences without gaps
  task automatic send_item(command_t cmd, logic [7:0] dev, logic [31:0] blk,
                           logic [4:0] idx);
    if ($urandom_range(0, 3) == 0) begin
      req.valid        <= 1'b0;
      req.command      <= 2'($urandom_range(0, 3));
      req.block_number <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    expected_rsps.push_back(cache_predict(cmd, dev, blk, idx));
    req.valid        <= 1'b1;
    req.command      <= cmd;
    req.device       <= dev;
    req.block_number <= blk;
    req.buffer_index <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_get(logic [7:0] dev, logic [31:0] blk);
    send_item(CMD_GET, dev, blk, '0);
  endtask

  task automatic send_op(command_t cmd, logic [4:0] idx);
    send_item(cmd, 8'($urandom), $urandom, idx);
  endtask

  // response side
  initial begin
    cache_rsp_t want;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", 1, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.granted_buffer !== want.granted_buffer)
            report_mismatch("granted_buffer", rsp.granted_buffer, want.granted_buffer);
          if (rsp.tag_hit !== want.tag_hit)
            report_mismatch("tag_hit", rsp.tag_hit, want.tag_hit);
          if (rsp.needs_disk_read !== want.needs_disk_read)
            report_mismatch("needs_disk_read", rsp.needs_disk_read, want.needs_disk_read);
          if (rsp.reference_count !== want.reference_count)
            report_mismatch("reference_count", rsp.reference_count,
                            want.reference_count);
        end
        rsp_count++;
      end
      rsp.ready <= !stall_enable || ($urandom_range(0, 2) != 0);
    end
  end

  task automatic test_directed();
    send_get(8'd0, 32'd0);
    send_get(8'd0, 32'd0);
    send_get(8'hff, 32'hffff_ffff);
    send_get(8'h00, 32'd13);
    send_get(8'h5a, 32'd1);
    send_op(CMD_RELEASE, 5'd0);
    send_op(CMD_RELEASE, 5'd0);
    send_op(CMD_UNPIN, 5'd0);
    send_op(CMD_UNPIN, 5'd31);
    send_op(CMD_PIN, 5'd31);
    send_op(CMD_RELEASE, 5'd31);
    send_get(8'h5a, 32'd1);
    send_get(8'h5a, 32'd14);
    for (int i = 0; i < 8; i++) send_op(CMD_PIN, 5'd3);
  endtask

  // drive one buffer to the count ceiling and back down
  task automatic test_count_ceiling();
    for (int i = 0; i < 258; i++) send_op(CMD_PIN, 5'd7);
    send_get(mdl_device[7], mdl_block[7]);
    for (int i = 0; i < 256; i++) send_op(CMD_UNPIN, 5'd7);
  endtask

  // pin everything, ask for new blocks, then release everything
  task automatic test_exhaustion();
    for (int i = 0; i < NUM_BUFFERS; i++) send_op(CMD_PIN, i[4:0]);
    send_get(8'h11, 32'h1234_5678);
    send_get(8'h12, 32'd5);
    for (int i = 0; i < NUM_BUFFERS; i++) send_op(CMD_RELEASE, i[4:0]);
  endtask

  task automatic test_random(int n);
    logic [31:0] blk;
    logic [4:0]  idx;
    int          k;
    for (int i = 0; i < n; i++) begin
      stall_enable = (i % 300) > 60;
      k = $urandom_range(0, 99);
      if (k < 45) begin
        if ($urandom_range(0, 1)) blk = $urandom_range(0, 40);
        else if ($urandom_range(0, 3) == 0) blk = $urandom;
        else blk = 32'hffff_ffc0 | 32'($urandom_range(0, 63));
        send_get($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2)),
                 blk);
      end else begin
        idx = 5'($urandom);
        if (k < 75) send_op(CMD_RELEASE, idx);
        else if (k < 88) send_op(CMD_PIN, idx);
        else send_op(CMD_UNPIN, idx);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int waited;
    rst = 1'b1;
    req.valid <= 1'b0;
    req.command <= CMD_GET;
    req.device <= '0;
    req.block_number <= '0;
    req.buffer_index <= '0;
    error_count = 0;
    sent_count = 0;
    rsp_count = 0;
    hit_count = 0;
    steal_count = 0;
    nofree_count = 0;
    zero_count = 0;
    stall_enable = 1'b0;
    cache_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    stall_enable = 1'b1;
    test_count_ceiling();
    test_exhaustion();
    test_random(900);
    req.valid <= 1'b0;
    waited = 0;
    while (expected_rsps.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    $display("sent %0d items, checked %0d responses", sent_count, rsp_count);
    $display("hits %0d, steals %0d, no-free %0d, count-zero %0d", hit_count,
             steal_count, nofree_count, zero_count);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
